>>> src/i2cm_pkg.sv
// Package for the I2C master transaction engine.
// Holds the transfer payload structs, the bus phase encoding and the engine state.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    typedef struct packed {
        logic       command;
        logic [6:0] slave_address;
        logic [7:0] write_count;
        logic [7:0] read_count;
        logic [7:0] write_data;
        logic       data_valid;
        logic       sda_in;
        logic       scl_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       byte_request;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_timed_out;
        logic       busy_res;
        logic       done_res;
        logic       status;
    } t_out_item;

    typedef enum logic [15:0] {
        PH_IDLE  = 16'b0000_0000_0000_0001,
        PH_STA_H = 16'b0000_0000_0000_0010,
        PH_STA_L = 16'b0000_0000_0000_0100,
        PH_STB   = 16'b0000_0000_0000_1000,
        PH_STC   = 16'b0000_0000_0001_0000,
        PH_STD   = 16'b0000_0000_0010_0000,
        PH_WBIT  = 16'b0000_0000_0100_0000,
        PH_WACK  = 16'b0000_0000_1000_0000,
        PH_WAIT  = 16'b0000_0001_0000_0000,
        PH_RWAIT = 16'b0000_0010_0000_0000,
        PH_RBIT  = 16'b0000_0100_0000_0000,
        PH_RACK  = 16'b0000_1000_0000_0000,
        PH_SPA_H = 16'b0001_0000_0000_0000,
        PH_SPA_L = 16'b0010_0000_0000_0000,
        PH_SPB   = 16'b0100_0000_0000_0000,
        PH_SPC   = 16'b1000_0000_0000_0000
    } t_phase;

    localparam logic [31:0] STRETCH_TIMEOUT_RESET = 32'd500;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  tick;
        logic [3:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [7:0]  writes_left;
        logic [7:0]  reads_left;
        logic [6:0]  target_address;
        logic [31:0] stretch_timer;
        logic        failed;
        logic        read_phase;
        logic        acked;
    } t_state;

endpackage

`default_nettype wire

>>> src/i2cm_step.sv
// One tick of the I2C master bus sequencer: next engine state and line/result outputs.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_step
    import i2cm_pkg::*;
(
    input  wire t_state      i_state,
    input  wire t_in_item    i_item,
    input  wire logic [31:0] i_timeout,
    output t_state           o_next,
    output t_out_item        o_result
);

    t_state    s;
    t_out_item res;

    always_comb begin
        s   = i_state;
        res = '0;
        res.scl_release = 1'b1;
        res.sda_release = 1'b1;
        res.busy_res    = 1'b1;

        // load a new transaction while idle
        if (s.phase == PH_IDLE && i_item.command) begin
            s.target_address = i_item.slave_address;
            s.writes_left    = i_item.write_count;
            s.reads_left     = i_item.read_count;
            s.failed         = 1'b0;
            s.tick           = 3'd0;
            if (i_item.write_count != 8'd0) begin
                s.read_phase = 1'b0;
                s.phase      = PH_STA_H;
            end else if (i_item.read_count != 8'd0) begin
                s.read_phase = 1'b1;
                s.phase      = PH_STA_H;
            end else begin
                s.phase = PH_SPA_H;
            end
        end

        if (s.phase == PH_WAIT) begin
            res.byte_request = 1'b1;
            if (i_item.data_valid) begin
                s.shift_byte = i_item.write_data;
                if (s.writes_left != 8'd0) begin
                    s.writes_left = s.writes_left - 8'd1;
                end
                s.bit_index = 4'd0;
                s.tick      = 3'd0;
                s.phase     = PH_WBIT;
            end
        end

        // clock released by the target: start sampling the byte
        if (s.phase == PH_RWAIT && i_item.scl_in) begin
            s.bit_index  = 4'd0;
            s.tick       = 3'd0;
            s.shift_byte = 8'd0;
            s.phase      = PH_RBIT;
        end

        unique case (s.phase)
            PH_IDLE: begin
                res.busy_res = 1'b0;
            end
            PH_STA_H: begin
                if (s.tick >= 3'd1) begin
                    s.tick  = 3'd0;
                    s.phase = PH_STB;
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_STA_L: begin
                res.scl_release = 1'b0;
                if (s.tick >= 3'd1) begin
                    s.tick  = 3'd0;
                    s.phase = PH_STB;
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_STB: begin
                if (s.tick >= 3'd1) begin
                    s.tick  = 3'd0;
                    s.phase = PH_STC;
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_STC: begin
                res.sda_release = 1'b0;
                if (s.tick >= 3'd1) begin
                    s.tick  = 3'd0;
                    s.phase = PH_STD;
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_STD: begin
                res.scl_release = 1'b0;
                res.sda_release = 1'b0;
                if (s.tick >= 3'd1) begin
                    s.shift_byte = {s.target_address, s.read_phase};
                    s.bit_index  = 4'd0;
                    s.tick       = 3'd0;
                    s.phase      = PH_WBIT;
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_WBIT: begin
                res.sda_release = s.shift_byte[7];
                res.scl_release = (s.tick >= 3'd2) && (s.tick < 3'd6);
                if (s.tick >= 3'd7) begin
                    s.shift_byte = {s.shift_byte[6:0], 1'b0};
                    s.bit_index  = s.bit_index + 4'd1;
                    s.tick       = 3'd0;
                    if (s.bit_index >= 4'd8) begin
                        s.phase = PH_WACK;
                    end
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_WACK: begin
                res.scl_release = (s.tick >= 3'd2);
                if (s.tick == 3'd4) begin
                    s.acked = (i_item.sda_in == 1'b0);
                end
                if (s.tick >= 3'd5) begin
                    s.tick = 3'd0;
                    priority if (s.read_phase) begin
                        s.stretch_timer = 32'd0;
                        s.phase         = PH_RWAIT;
                    end else if (!s.acked) begin
                        s.failed = 1'b1;
                        s.phase  = PH_SPA_L;
                    end else if (s.writes_left != 8'd0) begin
                        s.phase = PH_WAIT;
                    end else if (s.reads_left != 8'd0) begin
                        s.read_phase = 1'b1;
                        s.phase      = PH_STA_L;
                    end else begin
                        s.phase = PH_SPA_L;
                    end
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_WAIT: begin
                res.scl_release = 1'b0;
            end
            PH_RWAIT: begin
                // give up on a stretched clock: deliver zero with the flag
                if (s.stretch_timer >= i_timeout) begin
                    res.read_valid     = 1'b1;
                    res.read_timed_out = 1'b1;
                    if (s.reads_left != 8'd0) begin
                        s.reads_left = s.reads_left - 8'd1;
                    end
                    s.tick  = 3'd0;
                    s.phase = PH_RACK;
                end else begin
                    s.stretch_timer = s.stretch_timer + 32'd1;
                end
            end
            PH_RBIT: begin
                res.scl_release = (s.tick < 3'd4);
                if (s.tick == 3'd2) begin
                    s.shift_byte = {s.shift_byte[6:0], i_item.sda_in};
                end
                if (s.tick >= 3'd7) begin
                    s.bit_index = s.bit_index + 4'd1;
                    s.tick      = 3'd0;
                    if (s.bit_index >= 4'd8) begin
                        res.read_valid = 1'b1;
                        res.read_data  = s.shift_byte;
                        if (s.reads_left != 8'd0) begin
                            s.reads_left = s.reads_left - 8'd1;
                        end
                        s.phase = PH_RACK;
                    end
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_RACK: begin
                // NACK the last byte, ACK the others
                res.sda_release = (s.reads_left == 8'd0);
                res.scl_release = (s.tick >= 3'd2) && (s.tick < 3'd6);
                if (s.tick >= 3'd7) begin
                    s.tick = 3'd0;
                    if (s.reads_left != 8'd0) begin
                        s.stretch_timer = 32'd0;
                        s.phase         = PH_RWAIT;
                    end else begin
                        s.phase = PH_SPA_L;
                    end
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_SPA_H: begin
                res.sda_release = 1'b0;
                if (s.tick >= 3'd1) begin
                    s.tick  = 3'd0;
                    s.phase = PH_SPB;
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_SPA_L: begin
                res.scl_release = 1'b0;
                res.sda_release = 1'b0;
                if (s.tick >= 3'd1) begin
                    s.tick  = 3'd0;
                    s.phase = PH_SPB;
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_SPB: begin
                res.sda_release = 1'b0;
                if (s.tick >= 3'd1) begin
                    s.tick  = 3'd0;
                    s.phase = PH_SPC;
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            PH_SPC: begin
                if (s.tick >= 3'd1) begin
                    res.done_res = 1'b1;
                    res.status   = s.failed;
                    s.tick       = 3'd0;
                    s.phase      = PH_IDLE;
                end else begin
                    s.tick = s.tick + 3'd1;
                end
            end
            default: begin
                s.phase      = PH_IDLE;
                s.tick       = 3'd0;
                res.busy_res = 1'b0;
            end
        endcase

        o_next   = s;
        o_result = res;
    end

endmodule

`default_nettype wire

>>> src/i2c_master_transaction_engine_top.sv
// Top level of the I2C master transaction engine: input and result registers,
// engine state, stretch-timeout register. Depends on i2cm_pkg and i2cm_step.
//
// Usage:
//   Each input transfer on i_in_valid/o_in_ready is one bus tick: the sampled
//   SCL and SDA levels, a start command with its operands, and the write byte
//   offered with data_valid. Each tick gives exactly one result transfer on
//   o_out_valid/i_out_ready carrying the line releases for the next tick, the
//   write-byte request, any received byte and the busy/done/status flags.
//   A tick is taken into the input register, evaluated in one pass through the
//   sequencer logic and its result lands in the output register, from which it
//   is offered. One tick per cycle is sustained as long as the receiver takes
//   results; the only loop is the engine state register, updated once per tick.
//   When the receiver stalls, the held result stays put, one more input tick is
//   buffered in the input register, and o_in_ready then drops until the result
//   is taken; no tick is lost or repeated.
//   i_cfg_we writes the stretch timeout (reset 500); write it only while no
//   transaction or tick is in flight.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   engine to idle with both lines released.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transaction_engine_top
    import i2cm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data
);

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_state      r_state;
    t_state      n_state;
    t_out_item   n_out_item;
    logic [31:0] r_timeout;
    logic        advance;

    // move a tick into the result register when it is empty or being drained
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    i2cm_step u_step (
        .i_state   (r_state),
        .i_item    (r_in_item),
        .i_timeout (r_timeout),
        .o_next    (n_state),
        .o_result  (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_timeout   <= STRETCH_TIMEOUT_RESET;
            r_state     <= '{phase: PH_IDLE, default: '0};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

`default_nettype wire

>>> src/i2cm_checker.sv
// Port-level checks for the I2C master transaction engine, bound to the top level.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker
    import i2cm_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // nothing comes out the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a finished transaction is still flagged busy on its last tick; status only with done
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.done_res || o_out_data.status)
            |-> o_out_data.busy_res && o_out_data.done_res)
        else $error("done or status outside a busy tick");

    // a timed-out read delivers a zero byte
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.read_timed_out
            |-> o_out_data.read_valid && (o_out_data.read_data == 8'd0))
        else $error("timeout without a zero read byte");

    // waiting for a write byte keeps the clock line low
    a_request_scl_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.byte_request
            |-> !o_out_data.scl_release && o_out_data.busy_res)
        else $error("byte request without SCL held low");

endmodule

bind i2c_master_transaction_engine_top i2cm_checker u_i2cm_checker (.*);

`default_nettype wire
